@@ hdl/clfr_pkg.sv @@
package clfr_pkg;

   localparam int unsigned PrefixLen = 16;
   localparam int unsigned PrefixIdxW = $clog2(PrefixLen + 1);
   localparam int unsigned LengthW = 64;
   localparam int unsigned PayloadLenW = 32;

   localparam logic [7:0] CharCr = 8'h0d;
   localparam logic [7:0] CharLf = 8'h0a;
   localparam logic [7:0] CharZero = 8'h30;
   localparam logic [7:0] CharNine = 8'h39;

   localparam logic [PayloadLenW-1:0] MaxPayloadReset = 32'd1048576;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_EMPTY   = 2'd1,
      KIND_STATUS  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_NO_SEPARATOR = 3'd1,
      ST_BAD_HEADER   = 3'd2,
      ST_BAD_LENGTH   = 3'd3,
      ST_TOO_LARGE    = 3'd4,
      ST_TRUNCATED    = 3'd5
   } status_type;

   typedef struct packed {
      logic       valid;
      kind_type   kind;
      logic [7:0] payload_byte;
      logic       frame_last;
      status_type status;
   } result_type;

   function automatic logic [7:0] prefix_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:    c = "C";
         4'd1:    c = "o";
         4'd2:    c = "n";
         4'd3:    c = "t";
         4'd4:    c = "e";
         4'd5:    c = "n";
         4'd6:    c = "t";
         4'd7:    c = "-";
         4'd8:    c = "L";
         4'd9:    c = "e";
         4'd10:   c = "n";
         4'd11:   c = "g";
         4'd12:   c = "t";
         4'd13:   c = "h";
         4'd14:   c = ":";
         default: c = " ";
      endcase
      return c;
   endfunction

   // The separator alternates carriage return and line feed.
   function automatic logic [7:0] separator_char(input logic [1:0] idx);
      return idx[0] ? CharLf : CharCr;
   endfunction

endpackage

@@ hdl/clfr_parse.sv @@
module clfr_parse (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  logic [7:0]                        data_byte,
   input  logic                              end_of_buffer,
   input  logic [clfr_pkg::PayloadLenW-1:0]  max_payload,
   output clfr_pkg::result_type              result
);
   import clfr_pkg::*;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_BODY   = 2'd1,
      PH_ERROR  = 2'd2
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic [PrefixIdxW-1:0]   prefix_index_ff, prefix_index_in;
   logic [1:0]              sep_match_ff, sep_match_in;
   logic [LengthW-1:0]      length_acc_ff, length_acc_in;
   logic                    length_ovf_ff, length_ovf_in;
   logic                    digit_seen_ff, digit_seen_in;
   logic                    non_digit_ff, non_digit_in;
   logic                    mismatch_ff, mismatch_in;
   logic                    started_ff, started_in;
   logic [PayloadLenW-1:0]  body_rem_ff, body_rem_in;
   status_type              error_code_ff, error_code_in;

   logic                    prefix_done;
   logic                    sep_hit;
   logic                    is_digit;
   logic [3:0]              digit;
   logic [LengthW+3:0]      acc_wide;
   logic [LengthW+3:0]      acc_next;
   logic [PayloadLenW-1:0]  body_dec;
   logic                    too_large;

   assign prefix_done = (prefix_index_ff == PrefixIdxW'(PrefixLen));
   assign sep_hit     = (data_byte == separator_char(sep_match_ff));
   assign is_digit    = data_byte inside {[CharZero:CharNine]};
   assign digit       = 4'(data_byte - CharZero);
   assign acc_wide    = {4'b0, length_acc_ff};
   assign acc_next    = (acc_wide << 3) + (acc_wide << 1) + {{LengthW{1'b0}}, digit};
   assign body_dec    = body_rem_ff - 1'b1;
   assign too_large   = (length_acc_ff[LengthW-1:PayloadLenW] != '0)
                        || (length_acc_ff[PayloadLenW-1:0] > max_payload);

   always_comb begin
      phase_in        = phase_ff;
      prefix_index_in = prefix_index_ff;
      sep_match_in    = sep_match_ff;
      length_acc_in   = length_acc_ff;
      length_ovf_in   = length_ovf_ff;
      digit_seen_in   = digit_seen_ff;
      non_digit_in    = non_digit_ff;
      mismatch_in     = mismatch_ff;
      started_in      = started_ff;
      body_rem_in     = body_rem_ff;
      error_code_in   = error_code_ff;
      result          = '{valid: 1'b0, kind: KIND_PAYLOAD, payload_byte: 8'd0,
                          frame_last: 1'b0, status: ST_OK};

      if (end_of_buffer) begin
         result.valid = 1'b1;
         result.kind  = KIND_STATUS;
         case (phase_ff)
            PH_ERROR: result.status = error_code_ff;
            PH_BODY:  result.status = ST_TRUNCATED;
            default:  result.status = started_ff ? ST_NO_SEPARATOR : ST_OK;
         endcase
         phase_in        = PH_HEADER;
         prefix_index_in = '0;
         sep_match_in    = '0;
         length_acc_in   = '0;
         length_ovf_in   = 1'b0;
         digit_seen_in   = 1'b0;
         non_digit_in    = 1'b0;
         mismatch_in     = 1'b0;
         started_in      = 1'b0;
         body_rem_in     = '0;
         error_code_in   = ST_OK;
      end else begin
         case (phase_ff)
            PH_ERROR: begin
            end
            PH_BODY: begin
               result.valid        = 1'b1;
               result.kind         = KIND_PAYLOAD;
               result.payload_byte = data_byte;
               result.frame_last   = (body_dec == '0);
               body_rem_in         = body_dec;
               if (body_dec == '0) begin
                  phase_in        = PH_HEADER;
                  prefix_index_in = '0;
                  sep_match_in    = '0;
                  length_acc_in   = '0;
                  length_ovf_in   = 1'b0;
                  digit_seen_in   = 1'b0;
                  non_digit_in    = 1'b0;
                  mismatch_in     = 1'b0;
                  started_in      = 1'b0;
               end
            end
            default: begin
               phase_in   = PH_HEADER;
               started_in = 1'b1;
               if (sep_hit && sep_match_ff == 2'd3) begin
                  if (mismatch_ff || !prefix_done) begin
                     error_code_in = ST_BAD_HEADER;
                  end else if (!digit_seen_ff || non_digit_ff || length_ovf_ff) begin
                     error_code_in = ST_BAD_LENGTH;
                  end else if (too_large) begin
                     error_code_in = ST_TOO_LARGE;
                  end else begin
                     error_code_in = ST_OK;
                  end
                  if (error_code_in != ST_OK) begin
                     phase_in = PH_ERROR;
                  end else begin
                     body_rem_in     = length_acc_ff[PayloadLenW-1:0];
                     prefix_index_in = '0;
                     sep_match_in    = '0;
                     length_acc_in   = '0;
                     length_ovf_in   = 1'b0;
                     digit_seen_in   = 1'b0;
                     non_digit_in    = 1'b0;
                     mismatch_in     = 1'b0;
                     started_in      = 1'b0;
                     if (length_acc_ff[PayloadLenW-1:0] == '0) begin
                        result.valid = 1'b1;
                        result.kind  = KIND_EMPTY;
                     end else begin
                        phase_in = PH_BODY;
                     end
                  end
               end else if (sep_hit) begin
                  sep_match_in = sep_match_ff + 2'd1;
               end else if (sep_match_ff != 2'd0) begin
                  // A broken separator falls back into the header text. Its first
                  // character is never a prefix character or a digit, so it decides
                  // everything that the rest of the fallen-out bytes could change.
                  if (!mismatch_ff) begin
                     if (!prefix_done) begin
                        mismatch_in = 1'b1;
                     end else begin
                        non_digit_in = 1'b1;
                     end
                  end
                  sep_match_in = (data_byte == CharCr && sep_match_ff[0]) ? 2'd1 : 2'd0;
               end else if (!mismatch_ff) begin
                  if (!prefix_done) begin
                     if (data_byte == prefix_char(prefix_index_ff[3:0])) begin
                        prefix_index_in = prefix_index_ff + 1'b1;
                     end else begin
                        mismatch_in = 1'b1;
                     end
                  end else if (is_digit) begin
                     digit_seen_in = 1'b1;
                     if (!length_ovf_ff) begin
                        if (acc_next[LengthW+3:LengthW] != '0) begin
                           length_ovf_in = 1'b1;
                        end else begin
                           length_acc_in = acc_next[LengthW-1:0];
                        end
                     end
                  end else begin
                     non_digit_in = 1'b1;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         prefix_index_ff <= '0;
         sep_match_ff    <= '0;
         length_acc_ff   <= '0;
         length_ovf_ff   <= 1'b0;
         digit_seen_ff   <= 1'b0;
         non_digit_ff    <= 1'b0;
         mismatch_ff     <= 1'b0;
         started_ff      <= 1'b0;
         body_rem_ff     <= '0;
         error_code_ff   <= ST_OK;
      end else if (step) begin
         phase_ff        <= phase_in;
         prefix_index_ff <= prefix_index_in;
         sep_match_ff    <= sep_match_in;
         length_acc_ff   <= length_acc_in;
         length_ovf_ff   <= length_ovf_in;
         digit_seen_ff   <= digit_seen_in;
         non_digit_ff    <= non_digit_in;
         mismatch_ff     <= mismatch_in;
         started_ff      <= started_in;
         body_rem_ff     <= body_rem_in;
         error_code_ff   <= error_code_in;
      end
   end

endmodule

@@ hdl/content_length_frame_reader.sv @@
// Splits a byte buffer into frames of the form "Content-Length: <digits>" CR LF CR LF
// followed by that many payload bytes. Each input transaction carries one byte, or marks
// the end of the buffer when req_tlast is high. Payload bytes come out as they arrive,
// with rsp_tlast on the last byte of a frame; a zero-length frame gives one empty-frame
// result, and the end of a buffer gives one status result (ok, no separator, bad header,
// bad length, too large or truncated). After an error, bytes are dropped until the end
// of the buffer, and frames already delivered are not withdrawn, so a nonzero status
// means the whole buffer should be discarded. The block takes one transaction per cycle
// while rsp_tready does not stall the output; the parser works between the input
// register and the output register, and its per-byte update sets the throughput. The
// max_payload limit is to be written through csr_wr_en only while no transaction is in
// flight; the user is bound by this, as the block itself does not enforce it.
module content_length_frame_reader (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte[7:0]
   input  logic        req_tlast,   // end_of_buffer
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // payload_byte[7:0], status[10:8], zero[15:11]
   output logic        rsp_tlast,   // frame_last
   output logic [1:0]  rsp_tuser,   // kind[1:0]
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data  // max_payload[31:0]
);
   import clfr_pkg::*;

   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_byte_ff;
   logic                   in_eob_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_data_ff;
   logic [PayloadLenW-1:0] max_payload_ff;
   logic                   out_free;
   logic                   advance;
   result_type             result;

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign advance     = in_valid_ff && out_free;
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign rsp_valid_in = out_free ? (advance && result.valid) : rsp_valid_ff;

   clfr_parse u_parse (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .data_byte     (in_byte_ff),
      .end_of_buffer (in_eob_ff),
      .max_payload   (max_payload_ff),
      .result        (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         max_payload_ff <= MaxPayloadReset;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            max_payload_ff <= csr_wr_data;
         end
      end
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_eob_ff  <= req_tlast;
      end
      if (advance && result.valid) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_data_ff.status, rsp_data_ff.payload_byte};
   assign rsp_tlast  = rsp_data_ff.frame_last;
   assign rsp_tuser  = rsp_data_ff.kind;

endmodule

@@ hdl/clfr_checker.sv @@
module clfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic [1:0]  rsp_tuser,
   input logic        csr_wr_en,
   input logic [31:0] csr_wr_data
);
   import clfr_pkg::*;

   // A stalled result keeps its contents until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // Only payload transactions carry data or a frame end.
   a_non_payload_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_PAYLOAD |-> !rsp_tlast && rsp_tdata[7:0] == 8'd0)
      else $error("marker or status carries payload fields");

   a_status_only: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_STATUS |-> rsp_tdata[10:8] == ST_OK)
      else $error("status field set outside a status transaction");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:11] == 5'd0 && rsp_tdata[10:8] <= ST_TRUNCATED
         && rsp_tuser <= KIND_STATUS)
      else $error("result code out of range");

endmodule

bind content_length_frame_reader clfr_checker u_clfr_checker (.*);
